>>> hw/rtl/pclcd_pkg.sv
package pclcd_pkg;

    // Bus access kinds carried on the input tuser.
    typedef enum logic [1:0] {
        OP_CMD    = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2,
        OP_STATUS = 2'd3
    } op_t;

    // Command groups decoded from the upper nibble of a command byte.
    localparam logic [3:0] CMD_GRP_PAGE   = 4'hB;
    localparam logic [3:0] CMD_GRP_COL_HI = 4'h1;
    localparam logic [3:0] CMD_GRP_COL_LO = 4'h0;

    // Whole-byte command codes; the volume command is followed by its level byte.
    localparam logic [7:0] CMD_VOLUME      = 8'h81;
    localparam logic [7:0] CMD_DISPLAY_OFF = 8'hAE;
    localparam logic [7:0] CMD_DISPLAY_ON  = 8'hAF;

    // Status byte: busy (bit 7) is never set, bit 5 flags a blanked display.
    localparam logic [7:0] STATUS_DISPLAY_OFF = 8'h20;
    localparam logic [7:0] STATUS_IDLE_ON     = 8'h00;

endpackage

>>> hw/rtl/pclcd_ram.sv
module pclcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1408
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/page_column_lcd_controller.sv
// Page/column addressed graphic display controller as seen from its host bus.
//
// Input channel (s_axis): one transfer is one bus access. tuser carries the
// access kind (command write, data write, data read, status read) and tdata
// the command or display byte, which is ignored on reads.
// Output channel (m_axis): exactly one transfer per accepted access. tdata is
// the previous read latch on a data read, the status byte on a status read
// and zero on writes.
//
// The result of an access is registered and presented on m_axis in the cycle
// after it is accepted. The block takes one access per cycle while the
// receiver keeps taking results; the display RAM is a single synchronous
// memory with one write and one read port, and a read's latch reload is taken
// from the RAM output in the cycle after, with the RAM output forwarded to a
// read that follows straight away.
// Reset clears the page and column pointers, the read latch, the volume
// state and the display enable; the display RAM contents stay undefined until
// written, so software clears it before reading. When the receiver stalls,
// the result waits in the output register and s_axis_tready drops until it
// has been taken, so no result is ever lost or repeated.
module page_column_lcd_controller #(
    parameter int RAM_PAGES   = 11,
    parameter int RAM_COLUMNS = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] bus_byte
    input  logic [1:0] s_axis_tuser,   // [1:0] op
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [7:0] read_byte
);

    localparam int RAM_DEPTH = RAM_PAGES * RAM_COLUMNS;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);

    // Controller registers.
    logic [3:0]  page_reg,        page_next;
    logic [6:0]  column_reg,      column_next;
    logic [7:0]  read_latch_reg,  read_latch_next;
    logic        vol_pending_reg, vol_pending_next;
    logic [7:0]  volume_reg,      volume_next;
    logic        disp_on_reg,     disp_on_next;

    // Latch reload in flight: the RAM output arrives in the cycle after a read.
    logic        fill_pend_reg,   fill_pend_next;
    logic        fill_valid_reg,  fill_valid_next;

    // Output register.
    logic        out_valid_reg,   out_valid_next;
    logic [7:0]  out_data_reg,    out_data_next;

    logic        accept;
    logic        loc_valid;
    logic [ADDR_W-1:0] ram_addr;
    logic        ram_we;
    logic        ram_re;
    logic [7:0]  ram_rdata;
    logic [7:0]  latch_cur;
    logic [7:0]  col_inc;
    logic [7:0]  cmd_byte;
    pclcd_pkg::op_t op;

    assign op       = pclcd_pkg::op_t'(s_axis_tuser);
    assign cmd_byte = s_axis_tdata;

    // The output register frees up in the same cycle as it is taken.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign loc_valid = ({1'b0, page_reg} < 5'(RAM_PAGES)) &&
                       ({1'b0, column_reg} < 8'(RAM_COLUMNS));
    assign ram_addr  = ADDR_W'(32'(page_reg) * 32'(RAM_COLUMNS) + 32'(column_reg));

    // Current read latch value, with the pending RAM output forwarded.
    assign latch_cur = fill_pend_reg ? (fill_valid_reg ? ram_rdata : 8'h00)
                                     : read_latch_reg;

    assign col_inc = {1'b0, column_reg} + 8'd1;

    assign ram_we = accept && (op == pclcd_pkg::OP_WRITE) && loc_valid;
    assign ram_re = accept && (op == pclcd_pkg::OP_READ) && loc_valid;

    pclcd_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (s_axis_tdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        page_next        = page_reg;
        column_next      = column_reg;
        read_latch_next  = latch_cur;
        vol_pending_next = vol_pending_reg;
        volume_next      = volume_reg;
        disp_on_next     = disp_on_reg;
        fill_pend_next   = 1'b0;
        fill_valid_next  = fill_valid_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_data_next    = out_data_reg;

        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = 8'h00;
            unique case (op)
                pclcd_pkg::OP_CMD:
                begin
                    if (vol_pending_reg)
                    begin
                        // The byte after the volume command is the level itself.
                        volume_next      = cmd_byte;
                        vol_pending_next = 1'b0;
                    end
                    else
                    begin
                        unique case (cmd_byte[7:4])
                            pclcd_pkg::CMD_GRP_PAGE:
                                page_next = cmd_byte[3:0];
                            pclcd_pkg::CMD_GRP_COL_HI:
                                column_next = {cmd_byte[2:0], column_reg[3:0]};
                            pclcd_pkg::CMD_GRP_COL_LO:
                                column_next = {column_reg[6:4], cmd_byte[3:0]};
                            default:
                            begin
                                if (cmd_byte == pclcd_pkg::CMD_VOLUME)
                                begin
                                    vol_pending_next = 1'b1;
                                end
                                else if (cmd_byte == pclcd_pkg::CMD_DISPLAY_OFF ||
                                         cmd_byte == pclcd_pkg::CMD_DISPLAY_ON)
                                begin
                                    disp_on_next = cmd_byte[0];
                                end
                            end
                        endcase
                    end
                end
                pclcd_pkg::OP_WRITE:
                begin
                    // Column advances even when the write itself is dropped.
                    column_next = (col_inc >= 8'(RAM_COLUMNS)) ? 7'd0 : col_inc[6:0];
                end
                pclcd_pkg::OP_READ:
                begin
                    out_data_next   = latch_cur;
                    fill_pend_next  = 1'b1;
                    fill_valid_next = loc_valid;
                end
                pclcd_pkg::OP_STATUS:
                begin
                    out_data_next = disp_on_reg ? pclcd_pkg::STATUS_IDLE_ON
                                                : pclcd_pkg::STATUS_DISPLAY_OFF;
                end
                default:
                begin
                    out_data_next = 8'h00;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg        <= 4'd0;
            column_reg      <= 7'd0;
            read_latch_reg  <= 8'h00;
            vol_pending_reg <= 1'b0;
            volume_reg      <= 8'h00;
            disp_on_reg     <= 1'b0;
            fill_pend_reg   <= 1'b0;
            fill_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            page_reg        <= page_next;
            column_reg      <= column_next;
            read_latch_reg  <= read_latch_next;
            vol_pending_reg <= vol_pending_next;
            volume_reg      <= volume_next;
            disp_on_reg     <= disp_on_next;
            fill_pend_reg   <= fill_pend_next;
            fill_valid_reg  <= fill_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> hw/rtl/pclcd_checker.sv
module pclcd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [1:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    logic in_xfer;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // A held result blocks new accesses, so nothing can overwrite it.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while a result was stalled");

    // Every accepted access yields a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> m_axis_tvalid)
    else $error("no result after an accepted access");

    // Writes of either kind answer with zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (s_axis_tuser == pclcd_pkg::OP_CMD ||
                    s_axis_tuser == pclcd_pkg::OP_WRITE) |=> m_axis_tdata == 8'h00)
    else $error("write returned a non-zero byte");

    // Status never shows busy and only the display-off bit may be set.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && s_axis_tuser == pclcd_pkg::OP_STATUS |=>
            (m_axis_tdata & ~pclcd_pkg::STATUS_DISPLAY_OFF) == 8'h00)
    else $error("status byte has unexpected bits set");

    // A stalled result stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind page_column_lcd_controller pclcd_checker u_pclcd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
